// File: design/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and character mapping functions for the base64
// stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

  // Operating mode, as held in the mode register
  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  // Register word index (paddr bit 2)
  localparam logic REG_MODE = 1'b0;

  // Padding character
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Results one input transfer can cause
  localparam int unsigned MaxResults = 4;

  // Group state carried from one input transfer to the next
  typedef struct packed {
    logic [23:0] group_buf;  // collected bytes or sextets, newest low
    logic [1:0]  group_cnt;  // items held
    logic        stopped;    // decode met '=' or a non-alphabet byte
  } grp_state_t;

  // Results of one input transfer, handed to the output buffer
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;  // entry 0 goes out first
    logic [1:0]                 last_idx;  // index of the final entry
    logic                       any;       // at least one result
    logic                       eom;       // last entry closes the message
  } res_bundle_t;

  // Sextet to alphabet character
  function automatic logic [7:0] b64_char(logic [5:0] v);
    logic [7:0] c;
    c = {2'b00, v};
    if (v < 6'd26) begin
      b64_char = c + 8'd65;  // 'A'
    end else if (v < 6'd52) begin
      b64_char = c + 8'd71;  // 'a' - 26
    end else if (v < 6'd62) begin
      b64_char = c - 8'd4;   // '0' - 52
    end else if (v == 6'd62) begin
      b64_char = 8'h2B;      // '+'
    end else begin
      b64_char = 8'h2F;      // '/'
    end
  endfunction

  // Character to sextet; bit 6 set marks a character outside the alphabet
  function automatic logic [6:0] b64_sextet(logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) begin
      b64_sextet = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      b64_sextet = {1'b0, 6'(c - 8'd71)};
    end else if (c inside {[8'h30:8'h39]}) begin
      b64_sextet = {1'b0, 6'(c + 8'd4)};
    end else if (c == 8'h2B) begin
      b64_sextet = 7'd62;
    end else if (c == 8'h2F) begin
      b64_sextet = 7'd63;
    end else begin
      b64_sextet = 7'h40;
    end
  endfunction

endpackage

// File: design/b64sc_step.sv
// ----------------------------------------------------------------------------
// b64sc_step
// Combinational group logic: from the held group state, the mode and one
// input byte it works out the next group state and up to four results.
// ----------------------------------------------------------------------------
module b64sc_step
  import b64sc_pkg::*;
(
  input  mode_e       mode_i,
  input  grp_state_t  state_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_message_i,
  output grp_state_t  state_o,
  output res_bundle_t res_o
);

  logic [23:0] enc_shift;
  logic [23:0] dec_shift;
  logic [6:0]  sx;
  logic [1:0]  cnt_inc;

  assign enc_shift = {state_i.group_buf[15:0], data_byte_i};
  assign sx        = b64_sextet(data_byte_i);
  assign dec_shift = {state_i.group_buf[17:0], sx[5:0]};
  assign cnt_inc   = state_i.group_cnt + 2'd1;

  always_comb begin
    state_o         = state_i;
    res_o.bytes     = '0;
    res_o.last_idx  = 2'd0;
    res_o.any       = 1'b0;
    res_o.eom       = end_of_message_i;

    if (mode_i == MODE_ENCODE) begin
      if (state_i.group_cnt == 2'd2) begin
        // full group: four characters
        res_o.bytes[0] = b64_char(enc_shift[23:18]);
        res_o.bytes[1] = b64_char(enc_shift[17:12]);
        res_o.bytes[2] = b64_char(enc_shift[11:6]);
        res_o.bytes[3] = b64_char(enc_shift[5:0]);
        res_o.last_idx = 2'd3;
        res_o.any      = 1'b1;
        state_o.group_buf = '0;
        state_o.group_cnt = 2'd0;
      end else begin
        state_o.group_buf = enc_shift;
        state_o.group_cnt = cnt_inc;
        // flush of a partial group, padded to four
        if (end_of_message_i) begin
          res_o.any      = 1'b1;
          res_o.last_idx = 2'd3;
          res_o.bytes[3] = PAD_CHAR;
          if (cnt_inc == 2'd1) begin
            res_o.bytes[0] = b64_char(data_byte_i[7:2]);
            res_o.bytes[1] = b64_char({data_byte_i[1:0], 4'b0000});
            res_o.bytes[2] = PAD_CHAR;
          end else begin
            res_o.bytes[0] = b64_char(enc_shift[15:10]);
            res_o.bytes[1] = b64_char(enc_shift[9:4]);
            res_o.bytes[2] = b64_char({enc_shift[3:0], 2'b00});
          end
        end
      end
    end else begin
      if (!state_i.stopped) begin
        if (sx[6]) begin
          state_o.stopped = 1'b1;
        end else if (state_i.group_cnt == 2'd3) begin
          // full group: three bytes
          res_o.bytes[0] = dec_shift[23:16];
          res_o.bytes[1] = dec_shift[15:8];
          res_o.bytes[2] = dec_shift[7:0];
          res_o.last_idx = 2'd2;
          res_o.any      = 1'b1;
          state_o.group_buf = '0;
          state_o.group_cnt = 2'd0;
        end else begin
          state_o.group_buf = dec_shift;
          state_o.group_cnt = cnt_inc;
        end
      end
      // flush of a partial group: n sextets give n-1 bytes
      if (end_of_message_i) begin
        if (state_o.group_cnt == 2'd2) begin
          res_o.bytes[0] = state_o.group_buf[11:4];
          res_o.last_idx = 2'd0;
          res_o.any      = 1'b1;
        end else if (state_o.group_cnt == 2'd3) begin
          res_o.bytes[0] = state_o.group_buf[17:10];
          res_o.bytes[1] = state_o.group_buf[9:2];
          res_o.last_idx = 2'd1;
          res_o.any      = 1'b1;
        end
      end
    end

    // message end empties the group
    if (end_of_message_i) begin
      state_o.group_buf = '0;
      state_o.group_cnt = 2'd0;
      state_o.stopped   = 1'b0;
    end
  end

endmodule

// File: design/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec
// Base64 encoder/decoder on a byte stream with message framing; mode set
// through an APB-style register port.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------
//  in      | sink      | in_valid_i/in_ready_o | data_byte_i, end_of_message_i
//  out     | source    | out_valid_o/out_ready_i | out_byte_o, out_last_o
//  cfg     | APB slave | psel/penable/pready  | paddr, pwdata, prdata
//
// An input transfer is worked combinationally into a registered result buffer
// of up to four entries, which drains one output transfer per cycle while
// out_ready_i is high. A transfer with no results leaves the buffer empty;
// one with results holds off further input until its final entry has left
// through the single output port. The next input is taken in the cycle the
// final entry leaves. Reset clears the mode to encode and empties group state
// and buffer; a mode write also empties the group. Output stalls hold the
// buffer and back-pressure input.
//
module base64_stream_codec
  import b64sc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_message_i,
  // output stream
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mode_e       mode_q;
  grp_state_t  state_q, state_d;
  res_bundle_t res_d, buf_q;
  logic        buf_valid_q;
  logic [1:0]  rd_idx_q;
  logic        in_xfer, out_xfer, buf_done, cfg_wr;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MODE);
  assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENCODE;
    end else if (cfg_wr) begin
      mode_q <= mode_e'(pwdata[0]);
    end
  end

  // group logic
  b64sc_step u_step (
    .mode_i          (mode_q),
    .state_i         (state_q),
    .data_byte_i     (data_byte_i),
    .end_of_message_i(end_of_message_i),
    .state_o         (state_d),
    .res_o           (res_d)
  );

  // handshakes
  assign out_xfer   = out_valid_o && out_ready_i;
  assign buf_done   = rd_idx_q == buf_q.last_idx;
  assign in_ready_o = !buf_valid_q || (out_ready_i && buf_done);
  assign in_xfer    = in_valid_i && in_ready_o;

  // group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (cfg_wr) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // result buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      rd_idx_q    <= 2'd0;
    end else if (in_xfer && res_d.any) begin
      buf_valid_q <= 1'b1;
      rd_idx_q    <= 2'd0;
    end else if (out_xfer) begin
      if (buf_done) begin
        buf_valid_q <= 1'b0;
        rd_idx_q    <= 2'd0;
      end else begin
        rd_idx_q <= rd_idx_q + 2'd1;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk_i) begin
    if (in_xfer && res_d.any) begin
      buf_q <= res_d;
    end
  end

  assign out_valid_o = buf_valid_q;
  assign out_byte_o  = buf_q.bytes[rd_idx_q];
  assign out_last_o  = buf_q.eom && buf_done;

endmodule
